FILE: src/tbnd_pkg.sv
// Shared types, request codes and defaults for the timer bank.
// No dependencies; every other file in src imports this package.
package tbnd_pkg;

  localparam int NUM_TIMERS_DEF = 8;
  localparam int TPM_W          = 10;
  localparam int DELAY_W        = 16;
  localparam int PROD_W         = TPM_W + DELAY_W;
  localparam logic [31:0] IDLE_TICK = 32'hFFFF_FFFF;

  // Request codes
  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_CANCEL = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  timer_id;
    logic [15:0] wait_ms;
  } in_item_t;

  typedef struct packed {
    logic        expired_valid;
    logic [2:0]  expired_id;
    logic [31:0] next_deadline;
    logic        last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic in_take;     // latch the input beat
    logic rd_id;       // read the table at the request's timer id
    logic wr_start;    // write the new deadline for a start
    logic wr_cancel;   // idle the entry for a cancel
    logic tick_adv;    // advance the tick count
    logic scan_start;  // reset the scan and emit bookkeeping
    logic scan_step;   // scan pipeline runs this cycle
    logic out_load;    // load the output register
    logic out_expiry;  // loaded result reports an expiry
    logic emit_adv;    // move the emit pointer to the next timer
  } tbnd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] req_type;
    logic       id_ok;
    logic       cancel_rescan;
    logic       tick_due;
    logic       scan_done;
    logic       emit_none;
    logic       emit_hit;
    logic       emit_last;
    logic       out_free;
  } tbnd_stat_t;

endpackage

FILE: src/tbnd_ctrl.sv
// Sequencing state machine for the timer bank.
// Depends on tbnd_pkg; drives tbnd_datapath through tbnd_cmd_t.
module tbnd_ctrl import tbnd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  tbnd_stat_t st,
  output tbnd_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_START_WR = 3'd2;
  localparam logic [2:0] S_CANCEL   = 3'd3;
  localparam logic [2:0] S_TICK_CHK = 3'd4;
  localparam logic [2:0] S_SCAN     = 3'd5;
  localparam logic [2:0] S_EMIT     = 3'd6;
  localparam logic [2:0] S_RESULT   = 3'd7;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.in_take = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.req_type)
          REQ_START:  state_nxt = st.id_ok ? S_START_WR : S_RESULT;
          REQ_CANCEL: begin
            cmd.rd_id = 1'b1;
            state_nxt = st.id_ok ? S_CANCEL : S_RESULT;
          end
          REQ_TICK: begin
            cmd.tick_adv = 1'b1;
            state_nxt    = S_TICK_CHK;
          end
          default: state_nxt = S_RESULT;
        endcase
      end
      S_START_WR: begin
        cmd.wr_start = 1'b1;
        state_nxt    = S_RESULT;
      end
      S_CANCEL: begin
        cmd.wr_cancel = 1'b1;
        if (st.cancel_rescan) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_TICK_CHK: begin
        if (st.tick_due) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_done) begin
          state_nxt = (st.req_type == REQ_TICK) ? S_EMIT : S_RESULT;
        end
      end
      S_EMIT: begin
        // one beat per expired timer, or one empty beat when none hit
        if (st.emit_none) begin
          if (st.out_free) begin
            cmd.out_load = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else if (st.emit_hit) begin
          if (st.out_free) begin
            cmd.out_load   = 1'b1;
            cmd.out_expiry = 1'b1;
            cmd.emit_adv   = 1'b1;
            if (st.emit_last) state_nxt = S_IDLE;
          end
        end else begin
          cmd.emit_adv = 1'b1;
        end
      end
      S_RESULT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/tbnd_datapath.sv
// Deadline table, tick count, earliest-deadline register, scan pipeline
// and output register. Depends on tbnd_pkg; commanded by tbnd_ctrl.
module tbnd_datapath import tbnd_pkg::*; #(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  in_item_t         in_data,
  input  logic             cfg_valid,
  input  logic [TPM_W-1:0] cfg_ticks_per_ms,
  input  tbnd_cmd_t        cmd,
  output tbnd_stat_t       st,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(NUM_TIMERS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_TIMERS - 1);

  logic [TPM_W-1:0]      tpm_r;
  in_item_t              item_r;
  logic [PROD_W-1:0]     prod_r;
  logic [31:0]           now_r;
  logic [31:0]           earliest_r;
  logic [31:0]           mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] vld_r;
  logic [31:0]           rd_r;
  logic                  rd_vld_r;
  logic [CNT_W-1:0]      issue_cnt_r;
  logic                  pv_r;
  logic [IDX_W-1:0]      pidx_r;
  logic [31:0]           min_r;
  logic [NUM_TIMERS-1:0] hits_r;
  logic [IDX_W-1:0]      emit_idx_r;
  logic                  out_valid_r;
  out_item_t             out_r;

  logic [IDX_W-1:0]      id_idx;
  logic [IDX_W-1:0]      ra;
  logic [IDX_W-1:0]      wa;
  logic [31:0]           wd;
  logic                  we;
  logic [31:0]           rd_val;
  logic [31:0]           dt;
  logic [31:0]           wake;
  logic                  is_tick;
  logic                  issue;
  logic                  hit;
  logic [31:0]           new_val;
  logic [31:0]           new_min;
  logic                  scan_clear;
  logic [NUM_TIMERS-1:0] emit_bit;
  logic [NUM_TIMERS-1:0] hits_rem;

  assign id_idx  = IDX_W'(item_r.timer_id);
  assign is_tick = (item_r.req_type == REQ_TICK);
  assign rd_val  = rd_vld_r ? rd_r : IDLE_TICK;

  // Start deadline: now plus delay times rate, never less than one tick
  assign dt   = (prod_r == '0) ? 32'd1 : 32'(prod_r);
  assign wake = now_r + dt;

  // Scan element: expire on tick, fold into the running minimum
  assign issue      = cmd.scan_step && (issue_cnt_r != CNT_END);
  assign hit        = is_tick && (rd_val != IDLE_TICK) && (rd_val <= now_r);
  assign new_val    = hit ? IDLE_TICK : rd_val;
  assign new_min    = (new_val < min_r) ? new_val : min_r;
  assign scan_clear = pv_r && hit;

  // Emit bookkeeping
  assign emit_bit = NUM_TIMERS'(1) << emit_idx_r;
  assign hits_rem = hits_r & ~emit_bit;

  // Table port selection
  always_comb begin
    ra = cmd.scan_step ? issue_cnt_r[IDX_W-1:0] : id_idx;
    we = 1'b0;
    wa = id_idx;
    wd = IDLE_TICK;
    if (cmd.wr_start) begin
      we = 1'b1;
      wd = wake;
    end else if (cmd.wr_cancel) begin
      we = 1'b1;
    end else if (scan_clear) begin
      we = 1'b1;
      wa = pidx_r;
    end
  end

  // Deadline table, registered read on request
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (cmd.rd_id || cmd.scan_step) begin
      rd_r     <= mem[ra];
      rd_vld_r <= vld_r[ra];
    end
  end

  // Written-since-reset flags; an unwritten entry reads as idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[wa] <= 1'b1;
    end
  end

  // Config, time and earliest deadline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpm_r      <= TPM_W'(1);
      now_r      <= '0;
      earliest_r <= IDLE_TICK;
    end else begin
      if (cfg_valid) tpm_r <= cfg_ticks_per_ms;
      if (cmd.tick_adv) now_r <= now_r + 32'd1;
      if (cmd.wr_start && (wake < earliest_r)) begin
        earliest_r <= wake;
      end else if (pv_r && (pidx_r == IDX_LAST)) begin
        earliest_r <= new_min;
      end
    end
  end

  // Request latch and start product
  always_ff @(posedge clk) begin
    if (cmd.in_take) item_r <= in_data;
    prod_r <= PROD_W'(item_r.wait_ms) * PROD_W'(tpm_r);
  end

  // Scan pipeline: issue one read a cycle, process it the next
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      issue_cnt_r <= '0;
      min_r       <= IDLE_TICK;
      hits_r      <= '0;
      emit_idx_r  <= '0;
    end else begin
      if (issue) begin
        issue_cnt_r <= issue_cnt_r + CNT_W'(1);
        pidx_r      <= issue_cnt_r[IDX_W-1:0];
      end
      if (pv_r) begin
        min_r <= new_min;
        if (hit) hits_r[pidx_r] <= 1'b1;
      end
      if (cmd.out_load && cmd.out_expiry) hits_r <= hits_rem;
      if (cmd.emit_adv) emit_idx_r <= emit_idx_r + IDX_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.expired_valid <= cmd.out_expiry;
      out_r.expired_id    <= cmd.out_expiry ? 3'(emit_idx_r) : 3'd0;
      out_r.next_deadline <= earliest_r;
      out_r.last          <= cmd.out_expiry ? (hits_rem == '0) : 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Status
  always_comb begin
    st               = '0;
    st.req_type      = item_r.req_type;
    st.id_ok         = (32'(item_r.timer_id) < NUM_TIMERS);
    st.cancel_rescan = (earliest_r == rd_val);
    st.tick_due      = (earliest_r != IDLE_TICK) && (earliest_r <= now_r);
    st.scan_done     = pv_r && (pidx_r == IDX_LAST);
    st.emit_none     = (hits_r == '0);
    st.emit_hit      = |(hits_r & emit_bit);
    st.emit_last     = (hits_rem == '0);
    st.out_free      = !out_valid_r || out_ready;
  end

  // Output register is never overwritten while a beat waits
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> st.out_free)
    else $error("output register loaded while occupied");

  // An expiry beat is loaded only for a timer that actually hit
  a_expiry_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && cmd.out_expiry) |-> |(hits_r & emit_bit))
    else $error("expiry reported for a timer that did not hit");

  // The processing stage only follows a scan step
  a_scan_follow: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> $past(cmd.scan_step))
    else $error("scan element processed without an issued read");

  // Only one source drives the table write port
  a_wr_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.wr_start, cmd.wr_cancel, scan_clear}))
    else $error("table write port contention");

endmodule

FILE: src/timer_bank_next_deadline_core.sv
// Top level of the timer bank: controller plus datapath.
// Depends on tbnd_pkg, tbnd_ctrl and tbnd_datapath.
//
// A bank of NUM_TIMERS one-shot timers with a tick count that each tick
// request advances and the earliest pending deadline. One request is
// handled at a time; the output register lets the next request start
// while a result beat waits. Start goes through latch, dispatch, multiply
// and table write before the result. Cancel reads the entry at dispatch
// and writes it idle; the table is rescanned when the cancelled entry's
// deadline equals the earliest deadline. A tick with nothing due ends
// after its due check; otherwise the table is scanned through its single
// read port, one entry a cycle, then the expiry mask is walked one timer
// a cycle while the result side accepts each expiry beat, stalling while
// it does not. Table entries not written since reset read as idle through
// per-entry valid flags, so no clearing pass is needed. The configuration
// port is always ready.
module timer_bank_next_deadline_core import tbnd_pkg::*; #(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [TPM_W-1:0] cfg_ticks_per_ms
);

  tbnd_cmd_t  cmd;
  tbnd_stat_t st;

  assign cfg_ready = 1'b1;

  // Controller
  tbnd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath
  tbnd_datapath #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_data          (in_data),
    .cfg_valid        (cfg_valid),
    .cfg_ticks_per_ms (cfg_ticks_per_ms),
    .cmd              (cmd),
    .st               (st),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data)
  );

endmodule

FILE: test/tbnd_deadline_checker.sv
// Scoreboard for the timer bank: mirrors the deadline table from the beats it
// sees on the request and rate ports and checks every result beat in order.
// Depends on tbnd_pkg.
module tbnd_deadline_checker import tbnd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_item_t         in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_item_t        out_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [TPM_W-1:0] cfg_ticks_per_ms,
  output int               fail_count,
  output int               pending,
  output int               beats_seen,
  output int               expiries_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NT = NUM_TIMERS_DEF;

  // Mirrored bank state
  logic [31:0]      bank_deadline [NT];
  logic [31:0]      bank_earliest;
  logic [31:0]      bank_now;
  logic [TPM_W-1:0] bank_tpm;
  out_item_t        due_results [$];

  // Full rescan for the smallest armed deadline
  function automatic logic [31:0] lowest_deadline();
    logic [31:0] low;
    low = IDLE_TICK;
    for (int k = 0; k < NT; k++)
      if (bank_deadline[k] < low) low = bank_deadline[k];
    return low;
  endfunction

  function automatic out_item_t result_beat(logic hit, logic [2:0] id, logic fin);
    out_item_t beat;
    beat.expired_valid = hit;
    beat.expired_id    = id;
    beat.next_deadline = bank_earliest;
    beat.last          = fin;
    return beat;
  endfunction

  // Apply one request to the mirror and queue the result beats it produces
  task automatic apply_request(in_item_t req);
    logic [31:0]   span;
    logic [31:0]   wake;
    logic [31:0]   prior;
    logic [NT-1:0] hits;
    int            id;
    id   = int'(req.timer_id);
    hits = '0;
    case (req.req_type)
      REQ_START: begin
        if (id < NT) begin
          span = 32'(req.wait_ms) * 32'(bank_tpm);
          if (span == 32'd0) span = 32'd1;   // zero delay still waits one tick
          wake = bank_now + span;
          bank_deadline[id] = wake;
          if (wake < bank_earliest) bank_earliest = wake;
        end
      end
      REQ_CANCEL: begin
        if (id < NT) begin
          prior = bank_deadline[id];
          bank_deadline[id] = IDLE_TICK;
          if (bank_earliest == prior) bank_earliest = lowest_deadline();
        end
      end
      REQ_TICK: begin
        bank_now = bank_now + 32'd1;
        // scan only when the earliest deadline is armed and due
        if (bank_earliest != IDLE_TICK && bank_earliest <= bank_now) begin
          for (int k = 0; k < NT; k++) begin
            if (bank_deadline[k] != IDLE_TICK && bank_deadline[k] <= bank_now) begin
              hits[k] = 1'b1;
              bank_deadline[k] = IDLE_TICK;
            end
          end
          bank_earliest = lowest_deadline();
        end
      end
      default: ;   // spare code: no state change
    endcase
    if (hits == '0) begin
      due_results.push_back(result_beat(1'b0, 3'd0, 1'b1));
    end else begin
      for (int k = 0; k < NT; k++)
        if (hits[k])
          due_results.push_back(result_beat(1'b1, 3'(k), ((hits >> (k + 1)) == '0)));
    end
  endtask

  task automatic compare_beat(out_item_t got);
    out_item_t want;
    if (due_results.size() == 0) begin
      $error("unexpected result beat: expired_id %0d next_deadline %0h",
             got.expired_id, got.next_deadline);
      fail_count++;
      return;
    end
    want = due_results.pop_front();
    if (got.expired_valid !== want.expired_valid) begin
      $error("expired_valid: expected %0d, got %0d", want.expired_valid, got.expired_valid);
      fail_count++;
    end
    if (got.expired_id !== want.expired_id) begin
      $error("expired_id: expected %0d, got %0d", want.expired_id, got.expired_id);
      fail_count++;
    end
    if (got.next_deadline !== want.next_deadline) begin
      $error("next_deadline: expected %0h, got %0h", want.next_deadline, got.next_deadline);
      fail_count++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      fail_count++;
    end
  endtask

  // Results are checked before the same edge's request is applied
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NT; k++) bank_deadline[k] = IDLE_TICK;
      bank_earliest = IDLE_TICK;
      bank_now      = '0;
      bank_tpm      = TPM_W'(1);
      due_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        compare_beat(out_data);
        beats_seen++;
        if (out_data.expired_valid) expiries_seen++;
      end
      if (cfg_valid && cfg_ready) bank_tpm = cfg_ticks_per_ms;
      if (in_valid && in_ready) apply_request(in_data);
    end
    pending = due_results.size();
  end

endmodule

FILE: test/tb_timer_bank_next_deadline_core.sv
// Testbench top for timer_bank_next_deadline_core: clock, reset, request and
// rate stimulus, result-side stalls and the verdict.
// Depends on tbnd_pkg, the core and tbnd_deadline_checker.
module tb_timer_bank_next_deadline_core;
  timeunit 1ns;
  timeprecision 1ps;
  import tbnd_pkg::*;

  // Request code with no operation behind it
  localparam logic [1:0] REQ_SPARE = 2'd3;
  // Idle time before a rate write: covers the longest scan-and-emit pass
  localparam int SETTLE_CYCLES = 3 * NUM_TIMERS_DEF + 8;

  typedef enum {SINK_OPEN, SINK_COIN, SINK_HOLD} sink_mode_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [TPM_W-1:0] cfg_ticks_per_ms = '0;

  int fail_count;
  int pending;
  int beats_seen;
  int expiries_seen;

  int sent_total = 0;
  int burst_left = 4;
  int rates_used = 0;
  logic [TPM_W-1:0] rate_plan [5] = '{10'd0, 10'd2, 10'd1023, 10'd1000, 10'd1};

  sink_mode_t sink_mode = SINK_OPEN;
  int         sink_run = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  timer_bank_next_deadline_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_ticks_per_ms (cfg_ticks_per_ms)
  );

  tbnd_deadline_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_ticks_per_ms (cfg_ticks_per_ms),
    .fail_count       (fail_count),
    .pending          (pending),
    .beats_seen       (beats_seen),
    .expiries_seen    (expiries_seen)
  );

  // Result side: stretches of always-ready, coin-flip ready and hard stall
  always @(negedge clk) begin
    if (sink_run == 0) begin
      case ($urandom_range(0, 3))
        0, 1:    sink_mode = SINK_OPEN;
        2:       sink_mode = SINK_COIN;
        default: sink_mode = SINK_HOLD;
      endcase
      sink_run = (sink_mode == SINK_HOLD) ? $urandom_range(1, 6) : $urandom_range(4, 30);
    end
    sink_run--;
    case (sink_mode)
      SINK_OPEN: out_ready <= 1'b1;
      SINK_COIN: out_ready <= 1'($urandom_range(0, 1));
      default:   out_ready <= 1'b0;
    endcase
  end

  function automatic in_item_t request(logic [1:0] op, logic [2:0] id, logic [15:0] delay);
    in_item_t req;
    req.req_type = op;
    req.timer_id = id;
    req.wait_ms  = delay;
    return req;
  endfunction

  // Mostly short delays so timers really expire; some full-range delays park timers
  function automatic in_item_t random_request();
    in_item_t req;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      req.req_type = REQ_START;
    else if (pick < 58) req.req_type = REQ_CANCEL;
    else if (pick < 96) req.req_type = REQ_TICK;
    else                req.req_type = REQ_SPARE;
    req.timer_id = 3'($urandom_range(0, 7));
    req.wait_ms  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    return req;
  endfunction

  // Send one request beat; bursts end with a random gap or a full drain
  task automatic issue(in_item_t req);
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent_total++;
    burst_left--;
    if (sent_total == 60) burst_left = 0;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      if (sent_total == 60 || $urandom_range(0, 5) == 0) begin
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end else begin
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
  endtask

  // Wait until every expected beat is back and the core has gone quiet
  task automatic quiesce();
    if (in_valid) in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_rate(logic [TPM_W-1:0] rate);
    cfg_ticks_per_ms <= rate;
    cfg_valid        <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    rates_used++;
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_rate(TPM_W'(1));

    // Directed: min one tick, max delay, shared deadline, cancels, skipped scan
    issue(request(REQ_START, 3'd0, 16'd0));
    issue(request(REQ_START, 3'd7, 16'hFFFF));
    issue(request(REQ_START, 3'd3, 16'd2));
    issue(request(REQ_START, 3'd5, 16'd2));
    issue(request(REQ_START, 3'd6, 16'd4));
    issue(request(REQ_TICK, 3'd0, 16'd0));
    issue(request(REQ_CANCEL, 3'd6, 16'd0));     // not the earliest
    issue(request(REQ_TICK, 3'd0, 16'd0));       // two timers expire together
    issue(request(REQ_CANCEL, 3'd7, 16'd0));     // earliest: rescan to idle
    issue(request(REQ_CANCEL, 3'd2, 16'd0));     // already idle
    issue(request(REQ_TICK, 3'd7, 16'hFFFF));    // nothing armed, scan skipped
    issue(request(REQ_SPARE, 3'd5, 16'h5A5A));
    issue(request(REQ_START, 3'd1, 16'd1));
    issue(request(REQ_START, 3'd1, 16'd3));      // restart leaves a stale minimum
    issue(request(REQ_TICK, 3'd0, 16'd0));       // stale minimum due, no expiry
    issue(request(REQ_TICK, 3'd0, 16'd0));
    issue(request(REQ_TICK, 3'd0, 16'd0));
    for (int k = 0; k < NUM_TIMERS_DEF; k++)
      issue(request(REQ_START, 3'(k), 16'd0));
    issue(request(REQ_TICK, 3'd0, 16'd0));       // every timer expires at once

    // Random phases, one per tick rate
    foreach (rate_plan[p]) begin
      quiesce();
      write_rate(rate_plan[p]);
      repeat (15) issue(random_request());
    end
    quiesce();

    $display("Sent %0d requests across %0d tick-rate settings, zero and 1023 included.",
             sent_total, rates_used);
    $display("Checked %0d result beats, %0d of them timer expiries.",
             beats_seen, expiries_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: files.f
src/tbnd_pkg.sv
src/tbnd_ctrl.sv
src/tbnd_datapath.sv
src/timer_bank_next_deadline_core.sv
test/tbnd_deadline_checker.sv
test/tb_timer_bank_next_deadline_core.sv
